### hw/rtl/sfcd_pkg.sv
// Shared constants and types for the sync-framed channel deframer.
package sfcd_pkg;

   localparam int NUM_CHANNELS_DEF = 6;
   localparam int NUM_OUT          = 6;
   localparam int CHAN_W           = 16;
   localparam int BYTE_W           = 8;

   localparam logic [BYTE_W-1:0] SYNC_FIRST  = 8'hFF;
   localparam logic [BYTE_W-1:0] SYNC_SECOND = 8'hFE;

   typedef logic [CHAN_W-1:0] chan_type;

   typedef enum logic [1:0] {
      PH_HUNT  = 2'd0,
      PH_SYNC2 = 2'd1,
      PH_DATA  = 2'd2,
      PH_SKIP  = 2'd3
   } phase_type;

endpackage

### hw/rtl/sfcd_in_reg.sv
// Input register stage: holds one received byte until the framer takes it.
module sfcd_in_reg (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [sfcd_pkg::BYTE_W-1:0] req_rx_byte,
   input  logic                        advance,
   output logic                        byte_valid,
   output logic [sfcd_pkg::BYTE_W-1:0] byte_data
);

   logic                        valid_ff;
   logic                        valid_in;
   logic [sfcd_pkg::BYTE_W-1:0] byte_ff;

   assign req_ready = !valid_ff || advance;

   always_comb begin
      if (req_valid && req_ready) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // load payload on acceptance
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         byte_ff <= req_rx_byte;
      end
   end

   assign byte_valid = valid_ff;
   assign byte_data  = byte_ff;

endmodule

### hw/rtl/sfcd_frame_fsm.sv
// Frame state machine and channel store: sync hunt, payload collection, result build.
module sfcd_frame_fsm #(
   parameter int NUM_CHANNELS = sfcd_pkg::NUM_CHANNELS_DEF
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          step,
   input  logic [sfcd_pkg::BYTE_W-1:0]                   byte_data,
   output logic                                          emit,
   output sfcd_pkg::chan_type [sfcd_pkg::NUM_OUT-1:0]    chan_vals
);

   localparam int FRAME_BYTES = 2 * NUM_CHANNELS;
   localparam int CNT_W       = $clog2(FRAME_BYTES + 1);
   localparam int IDX_W       = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

   sfcd_pkg::phase_type phase_ff;
   sfcd_pkg::phase_type phase_in;
   logic [CNT_W-1:0]    cnt_ff;
   logic [CNT_W-1:0]    cnt_in;
   sfcd_pkg::chan_type  store_ff [NUM_CHANNELS];

   logic               is_first;
   logic               is_second;
   logic               last_byte;
   logic [IDX_W-1:0]   idx;
   sfcd_pkg::chan_type wr_value;

   assign is_first  = (byte_data == sfcd_pkg::SYNC_FIRST);
   assign is_second = (byte_data == sfcd_pkg::SYNC_SECOND);
   assign last_byte = (cnt_ff == CNT_W'(FRAME_BYTES - 1));
   assign idx       = IDX_W'(cnt_ff >> 1);

   // even byte opens a channel (high byte), odd byte completes it
   assign wr_value = cnt_ff[0] ? {store_ff[idx][sfcd_pkg::CHAN_W-1:sfcd_pkg::BYTE_W], byte_data}
                               : {byte_data, {sfcd_pkg::BYTE_W{1'b0}}};

   // next state
   always_comb begin
      unique case (phase_ff)
         sfcd_pkg::PH_HUNT: begin
            phase_in = is_first ? sfcd_pkg::PH_SYNC2 : sfcd_pkg::PH_HUNT;
         end
         sfcd_pkg::PH_SYNC2: begin
            phase_in = is_second ? sfcd_pkg::PH_DATA : sfcd_pkg::PH_HUNT;
         end
         sfcd_pkg::PH_DATA: begin
            priority if (is_second) begin
               phase_in = sfcd_pkg::PH_HUNT;
            end else if (is_first) begin
               phase_in = sfcd_pkg::PH_SYNC2;
            end else if (last_byte) begin
               phase_in = sfcd_pkg::PH_SKIP;
            end else begin
               phase_in = sfcd_pkg::PH_DATA;
            end
         end
         sfcd_pkg::PH_SKIP: begin
            phase_in = sfcd_pkg::PH_HUNT;
         end
         default: begin
            phase_in = sfcd_pkg::PH_HUNT;
         end
      endcase
   end

   // outputs: byte count and result strobe
   always_comb begin
      cnt_in = '0;
      emit   = 1'b0;
      if (phase_ff == sfcd_pkg::PH_DATA && !is_first && !is_second) begin
         if (last_byte) begin
            emit = 1'b1;
         end else begin
            cnt_in = cnt_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= sfcd_pkg::PH_HUNT;
         cnt_ff   <= '0;
      end else if (step) begin
         phase_ff <= phase_in;
         cnt_ff   <= cnt_in;
      end
   end

   // store every payload byte, including one that aborts the frame
   always_ff @(posedge clock) begin
      if (step && phase_ff == sfcd_pkg::PH_DATA) begin
         store_ff[idx] <= wr_value;
      end
   end

   // result view: the byte being stored is merged in; unused channels read zero
   for (genvar k = 0; k < sfcd_pkg::NUM_OUT; k++) begin : g_chan
      if (k < NUM_CHANNELS) begin : g_used
         assign chan_vals[k] = (phase_ff == sfcd_pkg::PH_DATA && idx == IDX_W'(k))
                               ? wr_value : store_ff[k];
      end else begin : g_unused
         assign chan_vals[k] = '0;
      end
   end

`ifndef SYNTHESIS
   a_count_idle_zero: assert property (@(posedge clock) disable iff (reset)
      phase_ff != sfcd_pkg::PH_DATA |-> cnt_ff == '0)
      else $error("byte count nonzero outside payload phase");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(FRAME_BYTES - 1))
      else $error("byte count beyond frame length");

   a_emit_skip: assert property (@(posedge clock) disable iff (reset)
      step && emit |=> phase_ff == sfcd_pkg::PH_SKIP && cnt_ff == '0)
      else $error("completed frame did not move to discard phase");
`endif

endmodule

### hw/rtl/sfcd_out_reg.sv
// Result register: holds one completed frame until the consumer takes it.
module sfcd_out_reg (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       load,
   input  sfcd_pkg::chan_type [sfcd_pkg::NUM_OUT-1:0] load_vals,
   output logic                                       out_free,
   output logic                                       rsp_valid,
   input  logic                                       rsp_ready,
   output sfcd_pkg::chan_type [sfcd_pkg::NUM_OUT-1:0] rsp_vals
);

   logic                                       valid_ff;
   logic                                       valid_in;
   sfcd_pkg::chan_type [sfcd_pkg::NUM_OUT-1:0] vals_ff;

   assign out_free = !valid_ff || rsp_ready;

   always_comb begin
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         vals_ff <= load_vals;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_vals  = vals_ff;

endmodule

### hw/rtl/sync_framed_channel_deframer.sv
// Top level of the sync-framed channel deframer.
//
// Feed one received serial byte per request. The block hunts for the sync
// pair 0xFF, 0xFE, then collects 2*NUM_CHANNELS payload bytes into 16-bit
// channels, high byte first, and returns one response with all channels
// when the last payload byte arrives; channel ports at or beyond
// NUM_CHANNELS read zero. A payload byte of 0xFE drops the frame and
// resumes the hunt; 0xFF drops it and counts as a new first sync byte. The
// byte that follows a completed frame is discarded. Throughput is one
// request per clock, save while a frame-completing byte waits: an input
// register feeds the framer, and a response register lets the next request
// in while a finished frame waits. A request that completes a frame passes
// through the input register and then the response register before its
// response shows up; only the byte that completes a frame waits, in the
// input register, while an earlier response is still held by the consumer.
module sync_framed_channel_deframer #(
   parameter int NUM_CHANNELS = sfcd_pkg::NUM_CHANNELS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [sfcd_pkg::BYTE_W-1:0] req_rx_byte,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [sfcd_pkg::CHAN_W-1:0] rsp_chan_0,
   output logic [sfcd_pkg::CHAN_W-1:0] rsp_chan_1,
   output logic [sfcd_pkg::CHAN_W-1:0] rsp_chan_2,
   output logic [sfcd_pkg::CHAN_W-1:0] rsp_chan_3,
   output logic [sfcd_pkg::CHAN_W-1:0] rsp_chan_4,
   output logic [sfcd_pkg::CHAN_W-1:0] rsp_chan_5
);

   logic                                       byte_valid;
   logic [sfcd_pkg::BYTE_W-1:0]                byte_data;
   logic                                       advance;
   logic                                       emit;
   logic                                       out_free;
   sfcd_pkg::chan_type [sfcd_pkg::NUM_OUT-1:0] chan_vals;
   sfcd_pkg::chan_type [sfcd_pkg::NUM_OUT-1:0] rsp_vals;

   // advance a held byte unless it completes a frame and the response slot is busy
   assign advance = byte_valid && (!emit || out_free);

   sfcd_in_reg u_in_reg (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_rx_byte (req_rx_byte),
      .advance     (advance),
      .byte_valid  (byte_valid),
      .byte_data   (byte_data)
   );

   sfcd_frame_fsm #(
      .NUM_CHANNELS (NUM_CHANNELS)
   ) u_frame_fsm (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .byte_data (byte_data),
      .emit      (emit),
      .chan_vals (chan_vals)
   );

   sfcd_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (advance && emit),
      .load_vals (chan_vals),
      .out_free  (out_free),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_vals  (rsp_vals)
   );

   assign rsp_chan_0 = rsp_vals[0];
   assign rsp_chan_1 = rsp_vals[1];
   assign rsp_chan_2 = rsp_vals[2];
   assign rsp_chan_3 = rsp_vals[3];
   assign rsp_chan_4 = rsp_vals[4];
   assign rsp_chan_5 = rsp_vals[5];

endmodule
